// ----- sv/csvt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants for the CSV byte stream tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [7:0] BYTE_LF    = 8'd10;
  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_QUOTE = 8'd34;
  localparam logic [7:0] SEP_RESET  = 8'd44;

  localparam logic [15:0] SHOW_MAX = 16'hFFFF;

  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_CELL   = 3'd1;
  localparam logic [2:0] KIND_ROW    = 3'd2;
  localparam logic [2:0] KIND_UNTERM = 3'd3;
  localparam logic [2:0] KIND_STRAY  = 3'd4;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_QSEEN
  } mode_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [15:0] row;
    logic [15:0] cell_no;
    logic        last;
  } res_t;

endpackage

// ----- sv/csvt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_in_if / csvt_out_if / csvt_cfg_if
// Valid/ready channels of the tokenizer: byte input, token output, config.
// ----------------------------------------------------------------------------
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface csvt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [15:0] row_number;
  logic [15:0] cell_number;
  logic        last;

  modport source (output valid, output kind, output out_byte, output row_number,
                  output cell_number, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input row_number,
                  input cell_number, input last, output ready);
endinterface

interface csvt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] separator;

  modport source (output valid, output separator, input ready);
  modport sink   (input valid, input separator, output ready);
endinterface

// ----- sv/csv_byte_stream_tokenizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_byte_stream_tokenizer_core
// CSV tokenizer: quoted cells, doubled quotes, CRLF folding, row/cell counts.
// Tokens reach the output port from a registered 4-entry token queue.
// Throughput: one byte per cycle while the queue has room for two tokens;
// a byte's two tokens leave one at a time by the single-token output port.
// Reset (rst_n low, synchronous): separator back to 44, parser at cell
// start, no row open, counters zero, token queue empty.
// ----------------------------------------------------------------------------
module csv_byte_stream_tokenizer_core
  import csvt_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  csvt_in_if.sink    in_if,
  csvt_out_if.source out_if,
  csvt_cfg_if.sink   cfg_if
);

  logic [7:0]            sep_r;
  mode_t                 mode_r;
  logic                  cr_held_r, cr_held_nxt;
  logic                  row_open_r;
  logic [COUNT_BITS-1:0] row_cnt_r;
  logic [COUNT_BITS-1:0] cell_cnt_r;

  logic                  accept;
  logic                  eoi;
  logic [7:0]            b;

  logic                  en_a, en_b;
  logic [7:0]            byte_a;
  mode_t                 mode_a, mode_b;
  logic                  ro_a, ro_b;
  logic [COUNT_BITS-1:0] row_a, row_b;
  logic [COUNT_BITS-1:0] cell_a, cell_b;
  logic                  emit_a, emit_b;
  res_t                  res_a, res_b;

  logic [1:0]            push_n;
  res_t                  d0, d1;
  logic                  space;
  res_t                  q;

  assign eoi    = in_if.end_of_input;
  assign b      = in_if.in_byte;
  assign accept = in_if.valid && in_if.ready;

  // held CR: released as a byte, or folded into the LF that follows
  assign en_a   = cr_held_r;
  assign byte_a = (!eoi && b == BYTE_LF) ? BYTE_LF : BYTE_CR;
  assign en_b   = eoi || (b != BYTE_CR && !(cr_held_r && b == BYTE_LF));
  assign cr_held_nxt = !eoi && (b == BYTE_CR);

  csvt_feed #(.COUNT_BITS(COUNT_BITS)) u_feed_a (
    .en_i       (en_a),
    .close_i    (1'b0),
    .byte_i     (byte_a),
    .sep_i      (sep_r),
    .mode_i     (mode_r),
    .row_open_i (row_open_r),
    .row_i      (row_cnt_r),
    .cell_i     (cell_cnt_r),
    .mode_o     (mode_a),
    .row_open_o (ro_a),
    .row_o      (row_a),
    .cell_o     (cell_a),
    .emit_o     (emit_a),
    .res_o      (res_a)
  );

  csvt_feed #(.COUNT_BITS(COUNT_BITS)) u_feed_b (
    .en_i       (en_b),
    .close_i    (eoi),
    .byte_i     (b),
    .sep_i      (sep_r),
    .mode_i     (mode_a),
    .row_open_i (ro_a),
    .row_i      (row_a),
    .cell_i     (cell_a),
    .mode_o     (mode_b),
    .row_open_o (ro_b),
    .row_o      (row_b),
    .cell_o     (cell_b),
    .emit_o     (emit_b),
    .res_o      (res_b)
  );

  always_comb begin
    push_n = accept ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
    d0     = emit_a ? res_a : res_b;
    d0.last = !(emit_a && emit_b);
    d1     = res_b;
    d1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r      <= SEP_RESET;
      mode_r     <= MODE_START;
      cr_held_r  <= 1'b0;
      row_open_r <= 1'b0;
      row_cnt_r  <= '0;
      cell_cnt_r <= '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        sep_r <= cfg_if.separator;
      end
      if (accept) begin
        mode_r     <= mode_b;
        cr_held_r  <= cr_held_nxt;
        row_open_r <= ro_b;
        row_cnt_r  <= row_b;
        cell_cnt_r <= cell_b;
      end
    end
  end

  csvt_res_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n_i (push_n),
    .d0_i     (d0),
    .d1_i     (d1),
    .space_o  (space),
    .valid_o  (out_if.valid),
    .ready_i  (out_if.ready),
    .q_o      (q)
  );

  assign cfg_if.ready       = 1'b1;
  assign in_if.ready        = space;
  assign out_if.kind        = q.kind;
  assign out_if.out_byte    = q.data;
  assign out_if.row_number  = q.row;
  assign out_if.cell_number = q.cell_no;
  assign out_if.last        = q.last;

  a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && eoi |=> !cr_held_r && !row_open_r && mode_r == MODE_START)
    else $error("end of input did not reset parse state");

  a_cr_held: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !eoi && b == BYTE_CR |=> cr_held_r)
    else $error("CR not held back");

  a_stall_has_tokens: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> out_if.valid)
    else $error("input stalled with empty token queue");

endmodule

// ----- sv/csvt_feed.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_feed
// One parser step: takes one byte (or an end-of-input close) against the
// current parse state and gives the next state and at most one token.
// ----------------------------------------------------------------------------
module csvt_feed
  import csvt_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                  en_i,
  input  logic                  close_i,
  input  logic [7:0]            byte_i,
  input  logic [7:0]            sep_i,
  input  mode_t                 mode_i,
  input  logic                  row_open_i,
  input  logic [COUNT_BITS-1:0] row_i,
  input  logic [COUNT_BITS-1:0] cell_i,
  output mode_t                 mode_o,
  output logic                  row_open_o,
  output logic [COUNT_BITS-1:0] row_o,
  output logic [COUNT_BITS-1:0] cell_o,
  output logic                  emit_o,
  output res_t                  res_o
);

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  mode_t                 m;
  logic                  ro;
  logic [COUNT_BITS-1:0] r;
  logic [COUNT_BITS-1:0] c;
  logic                  emit;
  logic                  quote_open;
  logic [2:0]            kind_v;
  logic [7:0]            data_v;
  logic [31:0]           r32;
  logic [31:0]           c32;

  always_comb begin
    m          = mode_i;
    ro         = row_open_i;
    r          = row_i;
    c          = cell_i;
    emit       = 1'b0;
    quote_open = 1'b0;
    kind_v     = KIND_DATA;
    data_v     = 8'd0;
    if (en_i && close_i) begin
      if (ro) begin
        emit = 1'b1;
        case (m)
          MODE_START: begin
            c      = sat_inc(c);
            kind_v = KIND_ROW;
          end
          MODE_QUOTED: kind_v = KIND_UNTERM;
          default:     kind_v = KIND_ROW;
        endcase
      end
      m  = MODE_START;
      ro = 1'b0;
    end else if (en_i) begin
      if (!ro) begin
        ro = 1'b1;
        r  = sat_inc(r);
        c  = '0;
      end
      if (m == MODE_START) begin
        c = sat_inc(c);
        if (byte_i == BYTE_QUOTE) begin
          m          = MODE_QUOTED;
          quote_open = 1'b1;
        end else begin
          m = MODE_PLAIN;
        end
      end
      if (!quote_open) begin
        case (m)
          MODE_PLAIN: begin
            emit = 1'b1;
            if (byte_i == BYTE_LF) begin
              kind_v = KIND_ROW;
              m      = MODE_START;
              ro     = 1'b0;
            end else if (byte_i == sep_i) begin
              kind_v = KIND_CELL;
              m      = MODE_START;
            end else begin
              data_v = byte_i;
            end
          end
          MODE_QUOTED: begin
            if (byte_i == BYTE_QUOTE) begin
              m = MODE_QSEEN;
            end else if (byte_i == BYTE_LF) begin
              emit   = 1'b1;
              kind_v = KIND_UNTERM;
              m      = MODE_START;
              ro     = 1'b0;
            end else begin
              emit   = 1'b1;
              data_v = byte_i;
            end
          end
          default: begin
            emit = 1'b1;
            if (byte_i == BYTE_QUOTE) begin
              data_v = BYTE_QUOTE;
              m      = MODE_QUOTED;
            end else if (byte_i == BYTE_LF) begin
              kind_v = KIND_ROW;
              m      = MODE_START;
              ro     = 1'b0;
            end else if (byte_i == sep_i) begin
              kind_v = KIND_CELL;
              m      = MODE_START;
            end else begin
              kind_v = KIND_STRAY;
              m      = MODE_START;
            end
          end
        endcase
      end
    end
  end

  assign r32 = 32'(r);
  assign c32 = 32'(c);

  assign mode_o     = m;
  assign row_open_o = ro;
  assign row_o      = r;
  assign cell_o     = c;
  assign emit_o     = emit;

  always_comb begin
    res_o.kind    = kind_v;
    res_o.data    = data_v;
    res_o.row     = (r32 > 32'(SHOW_MAX)) ? SHOW_MAX : r32[15:0];
    res_o.cell_no = (c32 > 32'(SHOW_MAX)) ? SHOW_MAX : c32[15:0];
    res_o.last    = 1'b0;
  end

endmodule

// ----- sv/csvt_res_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_res_fifo
// Four-entry token queue; takes up to two tokens per cycle, gives one.
// ----------------------------------------------------------------------------
module csvt_res_fifo
  import csvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n_i,
  input  res_t       d0_i,
  input  res_t       d1_i,
  output logic       space_o,
  output logic       valid_o,
  input  logic       ready_i,
  output res_t       q_o
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;

  res_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_r != '0);
  assign space_o = (cnt_r <= CW'(DEPTH - 2));
  assign q_o     = mem_r[rp_r];

  assign wp_nxt  = wp_r + AW'(push_n_i);
  assign rp_nxt  = rp_r + AW'(pop);
  assign cnt_nxt = cnt_r + CW'(push_n_i) - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n_i != 2'd0) begin
      mem_r[wp_r] <= d0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_r[wp_r + AW'(1)] <= d1_i;
    end
  end

endmodule

// ----- tb/csv_byte_stream_tokenizer_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_byte_stream_tokenizer_core_test
// Self-checking bench for the CSV tokenizer. A behavioral tokenizer in the
// bench predicts every token from the accepted input bytes. A checker compares
// each output transaction against the oldest predicted token. Covered:
// directed cell, row, stray and end-of-input cases, a sweep over separator
// values with random CSV text and noise, and backpressure.
// ----------------------------------------------------------------------------
module csv_byte_stream_tokenizer_core_test;
  import csvt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;

  logic clk;
  logic rst_n;

  csvt_in_if  in_ch ();
  csvt_out_if out_ch ();
  csvt_cfg_if cfg_ch ();

  csv_byte_stream_tokenizer_core #(
    .COUNT_BITS(16)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  // Tokenizer model state
  logic [7:0]  sep_reg   = SEP_RESET;
  mode_t       mode      = MODE_START;
  logic        cr_held   = 1'b0;
  logic        row_open  = 1'b0;
  logic [15:0] row_cnt   = '0;
  logic [15:0] cell_cnt  = '0;
  res_t        step_buf [2];
  int          step_emits;

  res_t pending_tokens [$];

  int fail_cnt    = 0;
  int items_sent  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  int hold_req    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == SHOW_MAX) ? v : v + 16'd1;
  endfunction

  task automatic push_token(input logic [2:0] kind, input logic [7:0] b);
    res_t t;
    if (step_emits < 2) begin
      t.kind    = kind;
      t.data    = (kind == KIND_DATA) ? b : 8'd0;
      t.row     = row_cnt;
      t.cell_no = cell_cnt;
      t.last    = 1'b0;
      step_buf[step_emits] = t;
      step_emits++;
    end
  endtask

  task automatic close_row();
    row_open = 1'b0;
    mode     = MODE_START;
  endtask

  task automatic tokenize_byte(input logic [7:0] b);
    if (!row_open) begin
      row_open = 1'b1;
      row_cnt  = sat_inc(row_cnt);
      cell_cnt = '0;
    end
    if (mode == MODE_START) begin
      cell_cnt = sat_inc(cell_cnt);
      if (b == BYTE_QUOTE) begin
        mode = MODE_QUOTED;
        return;
      end
      mode = MODE_PLAIN;
    end
    case (mode)
      MODE_PLAIN: begin
        if (b == BYTE_LF) begin
          push_token(KIND_ROW, 8'd0);
          close_row();
        end else if (b == sep_reg) begin
          push_token(KIND_CELL, 8'd0);
          mode = MODE_START;
        end else begin
          push_token(KIND_DATA, b);
        end
      end
      MODE_QUOTED: begin
        if (b == BYTE_QUOTE) begin
          mode = MODE_QSEEN;
        end else if (b == BYTE_LF) begin
          push_token(KIND_UNTERM, 8'd0);
          close_row();
        end else begin
          push_token(KIND_DATA, b);
        end
      end
      default: begin
        if (b == BYTE_QUOTE) begin
          push_token(KIND_DATA, BYTE_QUOTE);
          mode = MODE_QUOTED;
        end else if (b == BYTE_LF) begin
          push_token(KIND_ROW, 8'd0);
          close_row();
        end else if (b == sep_reg) begin
          push_token(KIND_CELL, 8'd0);
          mode = MODE_START;
        end else begin
          push_token(KIND_STRAY, 8'd0);
          mode = MODE_START;
        end
      end
    endcase
  endtask

  task automatic tokenize_step(input logic [7:0] b, input logic eoi);
    step_emits = 0;
    if (eoi) begin
      if (cr_held) begin
        cr_held = 1'b0;
        tokenize_byte(BYTE_CR);
      end
      if (row_open) begin
        if (mode == MODE_START) begin
          cell_cnt = sat_inc(cell_cnt);
          push_token(KIND_ROW, 8'd0);
        end else if (mode == MODE_QUOTED) begin
          push_token(KIND_UNTERM, 8'd0);
        end else begin
          push_token(KIND_ROW, 8'd0);
        end
      end
      close_row();
    end else if (cr_held) begin
      cr_held = 1'b0;
      if (b == BYTE_LF) begin
        tokenize_byte(BYTE_LF);
      end else begin
        tokenize_byte(BYTE_CR);
        if (b == BYTE_CR) cr_held = 1'b1;
        else tokenize_byte(b);
      end
    end else if (b == BYTE_CR) begin
      cr_held = 1'b1;
    end else begin
      tokenize_byte(b);
    end
    if (step_emits > 0) step_buf[step_emits-1].last = 1'b1;
    for (int i = 0; i < step_emits; i++) pending_tokens.push_back(step_buf[i]);
  endtask

  task automatic note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // Token checker
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind    = out_ch.kind;
      got.data    = out_ch.out_byte;
      got.row     = out_ch.row_number;
      got.cell_no = out_ch.cell_number;
      got.last    = out_ch.last;
      if (pending_tokens.size() == 0) begin
        note_fail($sformatf("unexpected token kind=%0d byte=%0d row=%0d cell=%0d last=%0b",
                            got.kind, got.data, got.row, got.cell_no, got.last));
      end else begin
        want = pending_tokens.pop_front();
        if (got != want)
          note_fail($sformatf({"token mismatch: exp kind=%0d byte=%0d row=%0d cell=%0d ",
                               "last=%0b, got kind=%0d byte=%0d row=%0d cell=%0d last=%0b"},
                              want.kind, want.data, want.row, want.cell_no, want.last,
                              got.kind, got.data, got.row, got.cell_no, got.last));
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("csv_byte_stream_tokenizer_core test failed");
      $finish;
    end
  end

  // Token receiver: stall pattern plus requested long hold-off
  initial begin
    int rx_tick;
    int rx_mode;
    int hold_left;
    rx_tick   = 0;
    rx_mode   = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      rx_tick++;
      if (rx_tick % 32 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= (rx_tick % 4 == 0);
          default: out_ch.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eoi);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= b;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tokenize_step(b, eoi);
    items_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eoi();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic pause_in();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    pause_in();
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_separator(input logic [7:0] v);
    wait_drain();
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.separator <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sep_reg = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_text();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return 8'($urandom_range(0, 255));
      1:       return BYTE_QUOTE;
      2:       return sep_reg;
      3:       return BYTE_CR;
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  task automatic send_row();
    int ncells;
    int len;
    int r;
    ncells = $urandom_range(1, 4);
    for (int c = 0; c < ncells; c++) begin
      if (c > 0) send_item(sep_reg, 1'b0);
      len = $urandom_range(0, 5);
      if ($urandom_range(0, 9) < 4) begin
        send_item(BYTE_QUOTE, 1'b0);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 29);
          if (r < 4) begin
            send_item(BYTE_QUOTE, 1'b0);
            send_item(BYTE_QUOTE, 1'b0);
          end else if (r == 4) begin
            send_item(BYTE_LF, 1'b0);
          end else begin
            send_item(pick_text(), 1'b0);
          end
        end
        send_item(BYTE_QUOTE, 1'b0);
        if ($urandom_range(0, 7) == 0) send_item(8'($urandom_range(32, 126)), 1'b0);
      end else begin
        for (int i = 0; i < len; i++) send_item(pick_text(), 1'b0);
      end
    end
    r = $urandom_range(0, 9);
    if (r < 6) begin
      send_item(BYTE_LF, 1'b0);
    end else if (r < 9) begin
      send_item(BYTE_CR, 1'b0);
      send_item(BYTE_LF, 1'b0);
    end else begin
      send_eoi();
    end
  endtask

  task automatic send_noise();
    int n;
    int r;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       send_item(BYTE_CR, 1'b0);
        1:       send_item(BYTE_LF, 1'b0);
        2:       send_item(BYTE_QUOTE, 1'b0);
        3:       send_item(sep_reg, 1'b0);
        4:       send_eoi();
        default: send_item(8'($urandom_range(0, 255)), 1'b0);
      endcase
    end
  endtask

  task automatic test_random_text(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 15) send_noise();
      else send_row();
    end
  endtask

  task automatic test_plain_and_quoted();
    send_str("a,\"b\"\"\"\n");
  endtask

  task automatic test_row_ends();
    send_str("\n");
    send_str("x,\r\n");
  endtask

  task automatic test_stray_and_quote_data();
    send_str("\"q\"z\n");
    send_str("a\"");
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_str("\n");
    send_str("\"\n");
  endtask

  task automatic test_end_of_input();
    send_str("\r");
    send_eoi();
    send_eoi();
  endtask

  task automatic test_backpressure();
    wait_drain();
    gaps_on  = 1'b0;
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_item(8'($urandom_range(97, 122)), 1'b0);
    send_str("\n");
    wait_drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_separator_sweep();
    logic [7:0] seps [8];
    seps = '{8'd59, 8'd0, 8'd255, BYTE_LF, BYTE_QUOTE, BYTE_CR, 8'd9, SEP_RESET};
    test_random_text(65);
    foreach (seps[i]) begin
      set_separator(seps[i]);
      test_random_text(65);
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = 8'd0;
    in_ch.end_of_input = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.separator   = 8'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_plain_and_quoted();
    test_row_ends();
    test_stray_and_quote_data();
    test_end_of_input();
    test_backpressure();
    test_separator_sweep();

    wait_drain();
    repeat (20) @(posedge clk);
    if (pending_tokens.size() != 0)
      note_fail($sformatf("%0d tokens never arrived", pending_tokens.size()));
    if (fail_cnt == 0) begin
      $display("csv_byte_stream_tokenizer_core test passed");
    end else begin
      $display("csv_byte_stream_tokenizer_core test failed");
    end
    $finish;
  end

endmodule
